// File: sv/ial_pkg.sv
// Shared types, constants and codes of the insertable array list.
`timescale 1ns / 1ps
`default_nettype none

package ial_pkg;

    // Storage depth of the list.
    localparam int DEPTH   = 256;
    // Width of a fill level or capacity that can hold DEPTH itself.
    localparam int CNT_W   = $clog2(DEPTH + 1);
    // Fixed field widths of the stream items.
    localparam int CMD_W   = 3;
    localparam int POS_W   = 9;
    localparam int WORD_W  = 32;
    localparam int STAT_W  = 2;
    localparam int OCNT_W  = 9;
    // Width that compares a position against a fill level without loss.
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
    // Read gather: cells are OR-ed in groups, then the group results.
    localparam int GROUP   = 16;
    localparam int NGROUPS = (DEPTH + GROUP - 1) / GROUP;
    // Packed stream widths, rounded up to whole bytes.
    localparam int S_DATA_W = ((CMD_W + POS_W + WORD_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((STAT_W + WORD_W + OCNT_W + OCNT_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_POP    = 3'd2,
        CMD_GET    = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_GATHER = 2'd1,
        S_MERGE  = 2'd2
    } state_t;

    // Per-cell write control.
    typedef struct packed {
        logic load;   // take the incoming word
        logic shift;  // take the word of the left neighbour
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: sv/insertable_array_list.sv
// Top level of the insertable array list: command decode, cell chain, read path.
// Successful get: group ORs registered in S_GATHER, result in S_MERGE; no item taken meanwhile.
// Other commands: result registered next cycle; one item per cycle unless m_tready stalls it.
// A new item is accepted while the previous result is being taken (output register).
// aresetn (synchronous, active low) empties the list, zeroes the capacity and drops any result.
// Cell contents have no reset; only entries below the fill level are ever read.
`timescale 1ns / 1ps
`default_nettype none

module insertable_array_list
    import ial_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // s_tdata fields, lowest bit up: cmd[2:0], position[11:3], word_in[43:12], zero pad
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // m_tdata fields, lowest bit up: status[1:0], word_out[33:2], count[42:34],
    // reported_capacity[51:43], zero pad
    output logic      [M_DATA_W-1:0] m_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready
);

    // ------------------------------------------------------------------
    // Item fields
    // ------------------------------------------------------------------
    cmd_t              in_cmd;
    logic [CMP_W-1:0]  in_pos;
    logic [WORD_W-1:0] in_word;

    assign in_cmd  = cmd_t'(s_tdata[CMD_W-1:0]);
    assign in_pos  = CMP_W'(s_tdata[CMD_W +: POS_W]);
    assign in_word = s_tdata[CMD_W + POS_W +: WORD_W];

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  cap_reg, cap_next;
    logic [CMP_W-1:0]  rpos_reg, rpos_next;
    logic              ovalid_reg, ovalid_next;
    status_t           ostat_reg, ostat_next;
    logic [WORD_W-1:0] oword_reg, oword_next;
    logic [CNT_W-1:0]  ocnt_reg, ocnt_next;
    logic [CNT_W-1:0]  ocap_reg, ocap_next;

    logic              accept;
    logic              out_free;
    logic [CMP_W-1:0]  fill_cmp;
    logic              is_full;
    logic [CNT_W:0]    cap_dbl;
    logic [CNT_W-1:0]  cap_grown;

    // Write controls for the cell chain.
    logic              wr_en;
    logic              wr_ins;
    logic [CMP_W-1:0]  wr_pos;

    logic [WORD_W-1:0] gathered;

    assign fill_cmp = CMP_W'(fill_reg);
    assign is_full  = (fill_reg == CNT_W'(DEPTH));
    assign out_free = !ovalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Capacity growth: 0 -> 1, then double, saturate at DEPTH.
    assign cap_dbl = {cap_reg, 1'b0};
    always_comb begin
        if (cap_reg == '0) begin
            cap_grown = CNT_W'(1);
        end else if (cap_dbl > (CNT_W + 1)'(DEPTH)) begin
            cap_grown = CNT_W'(DEPTH);
        end else begin
            cap_grown = cap_dbl[CNT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && in_cmd == CMD_GET && in_pos < fill_cmp) begin
                    state_next = S_GATHER;
                end
            end
            S_GATHER: state_next = S_MERGE;
            S_MERGE:  state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs and datapath updates
    // ------------------------------------------------------------------
    always_comb begin
        s_tready    = 1'b0;
        fill_next   = fill_reg;
        cap_next    = cap_reg;
        rpos_next   = rpos_reg;
        ovalid_next = ovalid_reg && !m_tready;
        ostat_next  = ostat_reg;
        oword_next  = oword_reg;
        ocnt_next   = ocnt_reg;
        ocap_next   = ocap_reg;
        wr_en       = 1'b0;
        wr_ins      = 1'b0;
        wr_pos      = fill_cmp;

        unique case (state_reg)
            S_IDLE: begin
                s_tready = out_free;
                if (accept) begin
                    // Default result: ok, no word, unchanged count and capacity.
                    ovalid_next = 1'b1;
                    ostat_next  = ST_OK;
                    oword_next  = '0;
                    ocnt_next   = fill_reg;
                    ocap_next   = cap_reg;
                    case (in_cmd)
                        CMD_PUSH: begin
                            if (is_full) begin
                                ostat_next = ST_FULL;
                            end else begin
                                wr_en     = 1'b1;
                                fill_next = fill_reg + CNT_W'(1);
                                ocnt_next = fill_next;
                                if (fill_reg == cap_reg) begin
                                    cap_next  = cap_grown;
                                    ocap_next = cap_grown;
                                end
                            end
                        end
                        CMD_INSERT: begin
                            if (in_pos > fill_cmp) begin
                                ostat_next = ST_RANGE;
                            end else if (is_full) begin
                                ostat_next = ST_FULL;
                            end else begin
                                wr_en     = 1'b1;
                                wr_ins    = 1'b1;
                                wr_pos    = in_pos;
                                fill_next = fill_reg + CNT_W'(1);
                                ocnt_next = fill_next;
                                if (fill_reg == cap_reg) begin
                                    cap_next  = cap_grown;
                                    ocap_next = cap_grown;
                                end
                            end
                        end
                        CMD_POP: begin
                            if (fill_reg == '0) begin
                                ostat_next = ST_EMPTY;
                            end else begin
                                fill_next = fill_reg - CNT_W'(1);
                                ocnt_next = fill_next;
                            end
                        end
                        CMD_GET: begin
                            if (in_pos >= fill_cmp) begin
                                ostat_next = ST_RANGE;
                            end else begin
                                // Hold the result back until the read tree settles.
                                ovalid_next = 1'b0;
                                rpos_next   = in_pos;
                            end
                        end
                        CMD_CLEAR: begin
                            fill_next = '0;
                            ocnt_next = '0;
                        end
                        default: begin
                            // Unused codes: report state unchanged.
                        end
                    endcase
                end
            end
            S_GATHER: begin
                // Group ORs are being captured this cycle.
            end
            S_MERGE: begin
                ovalid_next = 1'b1;
                oword_next  = gathered;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            cap_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            cap_reg    <= cap_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rpos_reg  <= rpos_next;
        ostat_reg <= ostat_next;
        oword_reg <= oword_next;
        ocnt_reg  <= ocnt_next;
        ocap_reg  <= ocap_next;
    end

    // ------------------------------------------------------------------
    // Cell chain: each cell passes its word to its right-hand neighbour
    // ------------------------------------------------------------------
    logic [DEPTH-1:0][WORD_W-1:0] chain_words;
    logic [DEPTH-1:0][WORD_W-1:0] rd_words;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        cell_ctrl_t        ctrl;
        logic              rd_sel;
        logic [WORD_W-1:0] left_word;

        // Load the new word at the write position; on insert, shift the
        // occupied entries above it up by one.
        assign ctrl.load  = wr_en && (CMP_W'(i) == wr_pos);
        assign ctrl.shift = wr_en && wr_ins && (CMP_W'(i) > wr_pos) &&
                            (CMP_W'(i) <= fill_cmp);
        assign rd_sel     = (CMP_W'(i) == rpos_reg);

        if (i == 0) begin : g_head
            assign left_word = '0;
        end else begin : g_body
            assign left_word = chain_words[i-1];
        end

        ial_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .rd_sel    (rd_sel),
            .word_in   (in_word),
            .left_word (left_word),
            .word_out  (chain_words[i]),
            .rd_word   (rd_words[i])
        );
    end

    // ------------------------------------------------------------------
    // Read path
    // ------------------------------------------------------------------
    ial_gather u_gather (
        .aclk       (aclk),
        .cell_words (rd_words),
        .rd_word    (gathered)
    );

    // ------------------------------------------------------------------
    // Result item
    // ------------------------------------------------------------------
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = M_DATA_W'({OCNT_W'(ocap_reg), OCNT_W'(ocnt_reg), oword_reg, ostat_reg});

endmodule

`default_nettype wire

// File: sv/ial_cell.sv
// One storage cell of the list chain.
`timescale 1ns / 1ps
`default_nettype none

module ial_cell
    import ial_pkg::*;
(
    input  wire logic              aclk,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic              rd_sel,
    input  wire logic [WORD_W-1:0] word_in,
    input  wire logic [WORD_W-1:0] left_word,
    output logic      [WORD_W-1:0] word_out,
    output logic      [WORD_W-1:0] rd_word
);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    always_comb begin
        word_next = word_reg;
        if (ctrl.load) begin
            word_next = word_in;
        end else if (ctrl.shift) begin
            word_next = left_word;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word_out = word_reg;
    // Drive the word onto the read gather only when addressed.
    assign rd_word  = rd_sel ? word_reg : '0;

endmodule

`default_nettype wire

// File: sv/ial_gather.sv
// Two-stage OR tree that collects the addressed cell word.
`timescale 1ns / 1ps
`default_nettype none

module ial_gather
    import ial_pkg::*;
(
    input  wire logic                         aclk,
    input  wire logic [DEPTH-1:0][WORD_W-1:0] cell_words,
    output logic      [WORD_W-1:0]            rd_word
);

    logic [NGROUPS-1:0][WORD_W-1:0] grp_reg;
    logic [NGROUPS-1:0][WORD_W-1:0] grp_next;

    always_comb begin
        for (int g = 0; g < NGROUPS; g++) begin
            grp_next[g] = '0;
            for (int j = 0; j < GROUP; j++) begin
                if (g * GROUP + j < DEPTH) begin
                    grp_next[g] = grp_next[g] | cell_words[g * GROUP + j];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        grp_reg <= grp_next;
    end

    always_comb begin
        rd_word = '0;
        for (int g = 0; g < NGROUPS; g++) begin
            rd_word = rd_word | grp_reg[g];
        end
    end

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for the insertable array list: stream stimulus, predictor, checker.
`timescale 1ns / 1ps

module tb;
    import ial_pkg::*;

    // Half of the 4 ns clock period.
    localparam realtime HALF_PERIOD = 2.0;
    // Hard stop for a run that hangs.
    localparam int CYCLE_LIMIT = 100000;
    // Random commands wanted after the directed part.
    localparam int RANDOM_ITEMS = 1150;
    // Window in which neither side idles.
    localparam int CALM_FROM = 1500;
    localparam int CALM_TO   = 2100;
    // Cycles to wait once nothing is outstanding.
    localparam int DRAIN_CYCLES = 10;

    // One command as it travels on s_tdata.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [POS_W-1:0]  pos;
        logic [CMD_W-1:0]  cmd;
    } list_cmd_t;

    // One result as predicted and as unpacked from m_tdata.
    typedef struct packed {
        status_t           status;
        logic [WORD_W-1:0] word;
        logic [OCNT_W-1:0] count;
        logic [OCNT_W-1:0] capacity;
    } list_result_t;

    // Shapes of the random bursts.
    typedef enum int {
        MODE_GROW,
        MODE_DRAIN,
        MODE_READ,
        MODE_NOISE
    } burst_mode_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tvalid;
    logic                m_tready = 1'b0;

    // Commands waiting to be driven, and results waiting to be seen.
    list_cmd_t    cmd_queue[$];
    list_result_t result_queue[$];

    // Predictor state: the list as the block should hold it.
    logic [WORD_W-1:0] list_slots[DEPTH];
    int                list_fill = 0;
    int                list_capacity = 0;
    int                peak_fill = 0;

    // Fill level tracked while the stimulus is built, to aim positions.
    int gen_fill = 0;
    int total_items = 0;

    int accepted_items = 0;
    int ignored_items = 0;
    int status_seen[4] = '{0, 0, 0, 0};
    int errors = 0;
    int cycle_count = 0;

    insertable_array_list i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // Capacity after a push or insert that finds the list at its capacity:
    // 0 goes to 1, anything else doubles, saturating at DEPTH.
    function automatic int grown(input int fill, input int capacity);
        int next_cap;
        if (fill != capacity) begin
            return capacity;
        end
        next_cap = (capacity == 0) ? 1 : capacity * 2;
        if (next_cap > DEPTH) begin
            next_cap = DEPTH;
        end
        return (next_cap > capacity) ? next_cap : capacity;
    endfunction

    // Apply one accepted command to the predicted list and queue its result.
    task automatic predict_list_result(input list_cmd_t c);
        list_result_t r;
        r.status   = ST_OK;
        r.word     = '0;
        case (c.cmd)
            CMD_PUSH: begin
                if (list_fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    list_capacity         = grown(list_fill, list_capacity);
                    list_slots[list_fill] = c.word;
                    list_fill++;
                end
            end
            CMD_INSERT: begin
                // Range check comes before the full check.
                if (int'(c.pos) > list_fill) begin
                    r.status = ST_RANGE;
                end else if (list_fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    list_capacity = grown(list_fill, list_capacity);
                    for (int i = list_fill; i > int'(c.pos); i--) begin
                        list_slots[i] = list_slots[i-1];
                    end
                    list_slots[c.pos] = c.word;
                    list_fill++;
                end
            end
            CMD_POP: begin
                if (list_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    list_fill--;
                end
            end
            CMD_GET: begin
                if (int'(c.pos) >= list_fill) begin
                    r.status = ST_RANGE;
                end else begin
                    r.word = list_slots[c.pos];
                end
            end
            CMD_CLEAR: begin
                // Capacity survives a clear.
                list_fill = 0;
            end
            default: begin
                // Unused codes change nothing and report ok.
                ignored_items++;
            end
        endcase
        if (list_fill > peak_fill) begin
            peak_fill = list_fill;
        end
        r.count    = list_fill[OCNT_W-1:0];
        r.capacity = list_capacity[OCNT_W-1:0];
        result_queue.insert(result_queue.size(), r);
    endtask

    // Queue one command and follow the fill level it leads to.
    task automatic add_item(input logic [CMD_W-1:0] cmd, input int pos,
                            input logic [WORD_W-1:0] word);
        list_cmd_t c;
        c.cmd  = cmd;
        c.pos  = pos[POS_W-1:0];
        c.word = word;
        cmd_queue.insert(cmd_queue.size(), c);
        total_items++;
        case (cmd)
            CMD_PUSH:   if (gen_fill < DEPTH) gen_fill++;
            CMD_INSERT: if (pos <= gen_fill && gen_fill < DEPTH) gen_fill++;
            CMD_POP:    if (gen_fill > 0) gen_fill--;
            CMD_CLEAR:  gen_fill = 0;
            default:    ;
        endcase
    endtask

    // Build one random command in the given burst shape.
    task automatic add_random_item(input burst_mode_t mode, output logic [CMD_W-1:0] cmd);
        int                roll;
        int                pos;
        logic [WORD_W-1:0] word;
        roll = $urandom_range(0, 99);
        word = $urandom;
        // Now and then use an extreme word.
        if ($urandom_range(0, 15) == 0) begin
            case ($urandom_range(0, 3))
                0:       word = 32'h8000_0000;
                1:       word = 32'h7FFF_FFFF;
                2:       word = 32'h0000_0000;
                default: word = 32'hFFFF_FFFF;
            endcase
        end
        case (mode)
            MODE_GROW:  cmd = (roll < 40) ? CMD_PUSH : (roll < 80) ? CMD_INSERT :
                              (roll < 92) ? CMD_GET : CMD_POP;
            MODE_DRAIN: cmd = (roll < 60) ? CMD_POP : (roll < 85) ? CMD_GET :
                              (roll < 97) ? CMD_PUSH : CMD_CLEAR;
            MODE_READ:  cmd = (roll < 70) ? CMD_GET : (roll < 82) ? CMD_INSERT :
                              (roll < 96) ? CMD_POP : CMD_CLEAR;
            default:    cmd = CMD_W'($urandom_range(0, 7));
        endcase
        // Aim positions at valid indexes mostly; stray across the whole field otherwise.
        if (mode == MODE_NOISE || $urandom_range(0, 9) == 0) begin
            pos = $urandom_range(0, 511);
        end else if (cmd == CMD_INSERT) begin
            pos = $urandom_range(0, gen_fill);
        end else if (gen_fill > 0) begin
            pos = $urandom_range(0, gen_fill - 1);
        end else begin
            pos = $urandom_range(0, 511);
        end
        add_item(cmd, pos, word);
    endtask

    // Stimulus: directed walk through the special cases, then random bursts.
    initial begin : p_stimulus
        int               done_random;
        int               burst_len;
        burst_mode_t      mode;
        logic [CMD_W-1:0] cmd;
        // Empty list: failing get, pop and insert beyond the end.
        add_item(CMD_GET, 0, 32'h1111_1111);
        add_item(CMD_POP, 0, 32'h0);
        add_item(CMD_INSERT, 1, 32'h2222_2222);
        // Insert at index 0 of an empty list grows capacity to 1, then 2, 4.
        add_item(CMD_INSERT, 0, 32'h7FFF_FFFF);
        add_item(CMD_PUSH, 0, 32'h8000_0000);
        add_item(CMD_PUSH, 511, 32'hFFFF_FFFF);
        // Insert in the middle shifts the tail; insert at the end acts as push.
        add_item(CMD_INSERT, 1, 32'h0000_0000);
        add_item(CMD_INSERT, 4, 32'h5A5A_5A5A);
        add_item(CMD_INSERT, 6, 32'hA5A5_A5A5);
        for (int i = 0; i < 5; i++) begin
            add_item(CMD_GET, i, 32'h0);
        end
        add_item(CMD_GET, 5, 32'h0);
        add_item(CMD_GET, 511, 32'hFFFF_FFFF);
        // Unused codes with every other field bit set.
        for (int code = CMD_CLEAR + 1; code < 8; code++) begin
            add_item(code[CMD_W-1:0], 511, 32'hFFFF_FFFF);
        end
        add_item(CMD_POP, 0, 32'h0);
        add_item(CMD_GET, 3, 32'h0);
        // Clear empties the list but keeps the capacity.
        add_item(CMD_CLEAR, 256, 32'h0);
        add_item(CMD_GET, 0, 32'h0);
        add_item(CMD_PUSH, 0, 32'h1234_5678);
        add_item(CMD_POP, 0, 32'h0);

        // First burst fills the list to DEPTH and beats on it while full.
        done_random = 0;
        mode        = MODE_GROW;
        burst_len   = 400;
        while (done_random < RANDOM_ITEMS) begin
            for (int i = 0; i < burst_len && done_random < RANDOM_ITEMS; i++) begin
                add_random_item(mode, cmd);
                if (cmd <= CMD_CLEAR) begin
                    done_random++;
                end
            end
            case ($urandom_range(0, 99)) inside
                [0:29]:  mode = MODE_GROW;
                [30:54]: mode = MODE_DRAIN;
                [55:79]: mode = MODE_READ;
                default: mode = MODE_NOISE;
            endcase
            burst_len = $urandom_range(20, 120);
        end

        // Hold reset, then release.
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for every item to be taken and every result to arrive.
        while (accepted_items != total_items || result_queue.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d commands (%0d unused codes); ok %0d, range %0d, empty %0d, full %0d",
                 accepted_items, ignored_items, status_seen[ST_OK], status_seen[ST_RANGE],
                 status_seen[ST_EMPTY], status_seen[ST_FULL]);
        $display("Peak fill %0d of %0d, final capacity %0d, %0d mismatches",
                 peak_fill, DEPTH, list_capacity, errors);
        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // Driver: predict on each accepted item, then present the next one or idle.
    always @(posedge aclk) begin : p_drive
        list_cmd_t next_item;
        logic      calm;
        calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_list_result(list_cmd_t'(s_tdata[$bits(list_cmd_t)-1:0]));
                accepted_items++;
            end
            // Advance only when the slot is free; hold the item otherwise.
            if (!s_tvalid || s_tready) begin
                if (cmd_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 15)) begin
                    next_item = cmd_queue.pop_front();
                    s_tdata   <= {{(S_DATA_W - $bits(list_cmd_t)){1'b0}}, next_item};
                    s_tvalid  <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random, compare each taken result with the oldest prediction.
    always @(posedge aclk) begin : p_check
        list_result_t expected;
        list_result_t actual;
        logic         calm;
        calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= 15);
            if (m_tvalid && m_tready) begin
                actual.status   = status_t'(m_tdata[1:0]);
                actual.word     = m_tdata[33:2];
                actual.count    = m_tdata[42:34];
                actual.capacity = m_tdata[51:43];
                if (result_queue.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time, actual);
                    errors++;
                end else begin
                    expected = result_queue.pop_front();
                    status_seen[expected.status]++;
                    if (actual.status !== expected.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, expected.status, actual.status);
                        errors++;
                    end
                    if (actual.word !== expected.word) begin
                        $display("%0t: word_out mismatch, expected %h, actual %h",
                                 $time, expected.word, actual.word);
                        errors++;
                    end
                    if (actual.count !== expected.count) begin
                        $display("%0t: count mismatch, expected %0d, actual %0d",
                                 $time, expected.count, actual.count);
                        errors++;
                    end
                    if (actual.capacity !== expected.capacity) begin
                        $display("%0t: capacity mismatch, expected %0d, actual %0d",
                                 $time, expected.capacity, actual.capacity);
                        errors++;
                    end
                end
            end
        end
    end

    // Count cycles; drop the run if it hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, result_queue.size());
            $display("tb failed");
            $finish;
        end
    end

endmodule

// File: files.f
sv/ial_pkg.sv
sv/ial_cell.sv
sv/ial_gather.sv
sv/insertable_array_list.sv
tb/sv/tb.sv
